// ===== src/assert_macros.svh =====
// assertion helpers for the comparator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is held
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication on top of the clocked check
`define ASSERT_IMPLY(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ===== src/relc_pkg.sv =====
// ----------------------------------------------------------------------------
// relc_pkg
// Shared types and constants of the relative error line comparator.
// ----------------------------------------------------------------------------
package relc_pkg;

	localparam int VALUE_W   = 32;
	localparam int ERR_W     = 16;
	localparam int COUNT_W   = 32;
	localparam int COL_W     = 6;
	localparam int THRESH_W  = 31;
	localparam int MASK_W    = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;
	localparam int QUO_W     = 16;
	localparam int PROD_W    = 39;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ZERO_THRESHOLD = 2'd0,
		CFG_TOLERANCE_PCT  = 2'd1,
		CFG_COLUMN_MASK    = 2'd2
	} relc_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_PREP,
		ST_SCALE,
		ST_DIV,
		ST_FIN
	} relc_state_t;

	typedef struct packed {
		logic               line_differs;
		logic [ERR_W-1:0]   line_max_error;
		logic [COUNT_W-1:0] differing_lines;
		logic [ERR_W-1:0]   overall_max_error;
	} relc_line_stats_t;

endpackage

// ===== src/relc_ifs.sv =====
// ----------------------------------------------------------------------------
// relc channel interfaces
// Valid/ready channels for column items, result items and register writes.
// ----------------------------------------------------------------------------
interface relc_item_if;
	import relc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value_a;
	logic signed [VALUE_W-1:0] value_b;
	logic                      both_numeric;
	logic [COL_W-1:0]          column_number;
	logic                      last_in_line;

	modport source (output valid, value_a, value_b, both_numeric, column_number,
		last_in_line, input ready);
	modport sink (input valid, value_a, value_b, both_numeric, column_number,
		last_in_line, output ready);
endinterface

interface relc_result_if;
	import relc_pkg::*;

	logic               valid;
	logic               ready;
	logic               column_differs;
	logic [ERR_W-1:0]   column_error;
	logic               line_done;
	logic               line_differs;
	logic [ERR_W-1:0]   line_max_error;
	logic [COUNT_W-1:0] differing_lines;
	logic [ERR_W-1:0]   overall_max_error;

	modport source (output valid, column_differs, column_error, line_done, line_differs,
		line_max_error, differing_lines, overall_max_error, input ready);
	modport sink (input valid, column_differs, column_error, line_done, line_differs,
		line_max_error, differing_lines, overall_max_error, output ready);
endinterface

interface relc_cfg_if;
	import relc_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/relative_error_line_comparator.sv =====
// ----------------------------------------------------------------------------
// relative_error_line_comparator
// Percentage error between paired Q16.16 values, per column and per line.
// ----------------------------------------------------------------------------
//  channel  role    payload
//  item     sink    value_a, value_b, both_numeric, column_number, last_in_line
//  result   source  column and line error fields, running statistics
//  cfg      sink    index, data (zero_threshold, tolerance_pct, column_mask)
//
//  one item at a time: item.ready is high only while the sequencer is idle;
//  the 16 quotient steps of the serial divider make up most of each item's run.
//  the result register is loaded in the final step (fin); a result that is
//  not taken stalls the sequencer in that step, the next item waits.
//  arst_n clears the sequencer, statistics and config registers (mask to all ones).
//  cfg.ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module relative_error_line_comparator #(
	parameter int MAX_COLUMNS     = 32,
	parameter int SATURATED_ERROR = 65535
) (
	input  logic          clk,
	input  logic          arst_n,
	relc_item_if.sink     item,
	relc_result_if.source result,
	relc_cfg_if.sink      cfg
);
	import relc_pkg::*;

	localparam logic [COL_W:0]   MAXC = (COL_W+1)'(MAX_COLUMNS);
	localparam logic [ERR_W-1:0] SAT  = ERR_W'(SATURATED_ERROR);
	localparam logic [COL_W-1:0] MASK_COLS = COL_W'(MASK_W);

	relc_state_t state_q, state_n;

	logic [THRESH_W-1:0] zero_threshold_q;
	logic [ERR_W-1:0]    tolerance_q;
	logic [MASK_W-1:0]   column_mask_q;

	logic [VALUE_W-1:0]  a_q, b_q;
	logic                cmp_q, last_q;
	logic [VALUE_W-1:0]  ma_q, mb_q, diff_q, big_q;
	logic                za_q, zb_q;
	logic [PROD_W-1:0]   p96_q;

	logic                sel;
	logic [COL_W-1:0]    col_m1;
	logic [VALUE_W-1:0]  ma, mb, absd;
	logic [VALUE_W:0]    d;
	logic [PROD_W-1:0]   prod;

	logic                accept;
	logic                div_start, div_done;
	logic [QUO_W-1:0]    quot;
	logic                fin_fire;
	logic [ERR_W-1:0]    q_cap, err;
	logic                differs;
	relc_line_stats_t    stats;

	logic                res_valid_q;
	logic                res_differs_q, res_done_q;
	logic [ERR_W-1:0]    res_err_q;
	relc_line_stats_t    res_stats_q;

	// column selection at the input
	always_comb begin
		col_m1 = item.column_number - 1'b1;
		sel = (item.column_number != '0) && ({1'b0, item.column_number} <= MAXC)
			&& ((column_mask_q == '1) || ((item.column_number <= MASK_COLS)
			&& column_mask_q[col_m1[$clog2(MASK_W)-1:0]]));
	end

	assign accept = item.valid && item.ready;

	// configuration writes
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_threshold_q <= '0;
			tolerance_q      <= '0;
			column_mask_q    <= '1;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_ZERO_THRESHOLD: zero_threshold_q <= cfg.data[THRESH_W-1:0];
				CFG_TOLERANCE_PCT:  tolerance_q      <= cfg.data[ERR_W-1:0];
				CFG_COLUMN_MASK:    column_mask_q    <= cfg.data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// magnitudes and absolute difference
	always_comb begin
		ma   = a_q[VALUE_W-1] ? (~a_q + 1'b1) : a_q;
		mb   = b_q[VALUE_W-1] ? (~b_q + 1'b1) : b_q;
		d    = {a_q[VALUE_W-1], a_q} - {b_q[VALUE_W-1], b_q};
		absd = d[VALUE_W] ? VALUE_W'(-d) : d[VALUE_W-1:0];
		// diff * 100 = diff * 96 + diff * 4
		prod = p96_q + ({{(PROD_W-VALUE_W){1'b0}}, diff_q} << 2);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			a_q    <= item.value_a;
			b_q    <= item.value_b;
			cmp_q  <= item.both_numeric && sel;
			last_q <= item.last_in_line;
		end
		if (state_q == ST_MAG) begin
			ma_q   <= ma;
			mb_q   <= mb;
			diff_q <= absd;
		end
		if (state_q == ST_PREP) begin
			big_q <= (ma_q > mb_q) ? ma_q : mb_q;
			za_q  <= ma_q < {1'b0, zero_threshold_q};
			zb_q  <= mb_q < {1'b0, zero_threshold_q};
			p96_q <= ({{(PROD_W-VALUE_W){1'b0}}, diff_q} << 6)
				+ ({{(PROD_W-VALUE_W){1'b0}}, diff_q} << 5);
		end
	end

	// quotient of diff * 25600 / big, low byte of the numerator is zero
	relc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (big_q),
		.numer_hi (prod[PROD_W-1:8]),
		.numer_lo ({prod[7:0], 8'h00}),
		.done     (div_done),
		.quotient (quot)
	);

	// column error from the zero tests and the quotient
	always_comb begin
		q_cap = (quot > SAT) ? SAT : quot;
		err   = '0;
		if (cmp_q) begin
			if (za_q && zb_q)
				err = '0;
			else if (za_q != zb_q)
				err = SAT;
			else if (big_q == '0)
				err = '0;
			else if (q_cap < tolerance_q)
				err = '0;
			else
				err = q_cap;
		end
		differs = err > tolerance_q;
	end

	relc_stats u_stats (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (fin_fire),
		.column_differs (differs),
		.column_error   (err),
		.line_done      (last_q),
		.stats          (stats)
	);

	// sequencer
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (item.valid) state_n = ST_MAG;
			ST_MAG:   state_n = ST_PREP;
			ST_PREP:  state_n = ST_SCALE;
			ST_SCALE: state_n = ST_DIV;
			ST_DIV:   if (div_done) state_n = ST_FIN;
			ST_FIN:   if (!res_valid_q || result.ready) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		item.ready = 1'b0;
		div_start  = 1'b0;
		fin_fire   = 1'b0;
		case (state_q)
			ST_IDLE:  item.ready = 1'b1;
			ST_SCALE: div_start  = 1'b1;
			ST_FIN:   fin_fire   = !res_valid_q || result.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (fin_fire)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			res_differs_q <= differs;
			res_err_q     <= err;
			res_done_q    <= last_q;
			res_stats_q   <= stats;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.column_differs    = res_differs_q;
	assign result.column_error      = res_err_q;
	assign result.line_done         = res_done_q;
	assign result.line_differs      = res_stats_q.line_differs;
	assign result.line_max_error    = res_stats_q.line_max_error;
	assign result.differing_lines   = res_stats_q.differing_lines;
	assign result.overall_max_error = res_stats_q.overall_max_error;

	`ASSERT_IMPLY(a_div_done_in_div, div_done, state_q == ST_DIV, "divider finished outside its step")
	`ASSERT_CLK(a_accept_starts, accept |=> state_q == ST_MAG, "accepted item did not start")
	`ASSERT_IMPLY(a_differs_nonzero, result.valid && result.column_differs, result.column_error > '0, "differing column with zero error")
	`ASSERT_IMPLY(a_line_flag_closes, result.valid && result.line_differs, result.line_done, "line flag without line end")

endmodule

// ===== src/relc_div.sv =====
// ----------------------------------------------------------------------------
// relc_div
// Restoring divider, one quotient bit per cycle, numerator low bits shifted in.
// ----------------------------------------------------------------------------
module relc_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [relc_pkg::VALUE_W-1:0]     divisor,
	input  logic [relc_pkg::VALUE_W-2:0]     numer_hi,
	input  logic [relc_pkg::QUO_W-1:0]       numer_lo,
	output logic                             done,
	output logic [relc_pkg::QUO_W-1:0]       quotient
);
	import relc_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [VALUE_W-1:0]   rem_q;
	logic [QUO_W-1:0]     num_q;
	logic [QUO_W-1:0]     quo_q;
	logic [VALUE_W-1:0]   div_q;
	logic [VALUE_W:0]     trial;
	logic                 fits;
	logic [VALUE_W:0]     rem_next;

	// shift in the next numerator bit and try one subtraction
	always_comb begin
		trial    = {rem_q, num_q[QUO_W-1]};
		fits     = trial >= {1'b0, div_q};
		rem_next = fits ? (trial - {1'b0, div_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, numer_hi};
			num_q <= numer_lo;
			quo_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next[VALUE_W-1:0];
			num_q <= {num_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== src/relc_stats.sv =====
// ----------------------------------------------------------------------------
// relc_stats
// Line flag and peak, differing line count and overall peak error.
// ----------------------------------------------------------------------------
module relc_stats (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          column_differs,
	input  logic [relc_pkg::ERR_W-1:0]    column_error,
	input  logic                          line_done,
	output relc_pkg::relc_line_stats_t    stats
);
	import relc_pkg::*;

	logic               line_flag_q;
	logic [ERR_W-1:0]   line_peak_q;
	logic [COUNT_W-1:0] line_count_q;
	logic [ERR_W-1:0]   global_peak_q;

	logic               flag_n;
	logic [ERR_W-1:0]   peak_n;
	logic [COUNT_W-1:0] count_n;
	logic [ERR_W-1:0]   global_n;

	always_comb begin
		flag_n   = line_flag_q | column_differs;
		peak_n   = (column_differs && (column_error > line_peak_q)) ? column_error
			: line_peak_q;
		count_n  = line_count_q;
		global_n = global_peak_q;
		if (line_done && flag_n) begin
			// count saturates at all ones
			if (line_count_q != '1)
				count_n = line_count_q + 1'b1;
			if (peak_n > global_peak_q)
				global_n = peak_n;
		end
		stats.line_differs      = line_done & flag_n;
		stats.line_max_error    = line_done ? peak_n : '0;
		stats.differing_lines   = count_n;
		stats.overall_max_error = global_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_flag_q   <= 1'b0;
			line_peak_q   <= '0;
			line_count_q  <= '0;
			global_peak_q <= '0;
		end else if (step) begin
			line_flag_q   <= line_done ? 1'b0 : flag_n;
			line_peak_q   <= line_done ? '0 : peak_n;
			line_count_q  <= count_n;
			global_peak_q <= global_n;
		end
	end

endmodule
